>>> hdl/hhr_pkg.sv
`default_nettype none
package hhr_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int RING_SIZE  = 2 * MAX_WIDTH + 3;
    localparam int ADDR_W     = $clog2(RING_SIZE);
    localparam int COL_W      = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W      = 16;
    localparam int TOT_W      = COL_W + ROW_W;
    localparam int GRAD_W     = 36;
    localparam int TAP_N      = 9;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [2:0] CFG_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_COS_ZEN = 3'd2;
    localparam logic [2:0] CFG_SIN_ZEN = 3'd3;
    localparam logic [2:0] CFG_COS_AZ  = 3'd4;
    localparam logic [2:0] CFG_SIN_AZ  = 3'd5;
    localparam logic [2:0] CFG_SCALE_X = 3'd6;
    localparam logic [2:0] CFG_SCALE_Y = 3'd7;

    localparam logic KIND_SAMPLE = 1'b0;

    typedef struct packed {
        logic        [12:0] image_width;
        logic        [15:0] image_height;
        logic        [14:0] cos_zenith;
        logic        [14:0] sin_zenith;
        logic signed [15:0] cos_azimuth;
        logic signed [15:0] sin_azimuth;
        logic        [23:0] scale_x;
        logic        [23:0] scale_y;
    } cfg_t;

    // one centre pixel handed from the window gatherer to the shader
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     center_nd;
        logic                     frame_end;
    } win_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_EVAL,
        F_READ,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MULA,
        B_SHIFT,
        B_MULB,
        B_SQRT,
        B_PREP,
        B_DIV,
        B_DONE
    } back_state_t;

endpackage
`default_nettype wire

>>> hdl/hhr_fifo.sv
`default_nettype none
module hhr_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire hhr_pkg::win_t push_data,
    output logic               full,
    input  wire logic          pop,
    output hhr_pkg::win_t      pop_data,
    output logic               empty
);
    import hhr_pkg::*;

    win_t                 mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (FIFO_AW+1)'(push && !full) - (FIFO_AW+1)'(pop && !empty);
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("pop on empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count overflow");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

endmodule
`default_nettype wire

>>> hdl/hhr_front.sv
`default_nettype none
module hhr_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hhr_pkg::cfg_t       cfg,
    input  wire logic                frame_clear,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                in_kind,
    input  wire logic [31:0]         in_elev,
    input  wire logic                in_nd,
    output logic                     push,
    output hhr_pkg::win_t            push_data,
    input  wire logic                full
);
    import hhr_pkg::*;

    logic [32:0]        line_mem [RING_SIZE];
    logic [32:0]        rd_reg;
    logic [ADDR_W-1:0]  raddr;

    front_state_t       state_reg, state_next;

    logic [COL_W-1:0]   wd_reg;
    logic [ROW_W-1:0]   ht_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [COL_W-1:0]   wd_eff;
    logic [ROW_W-1:0]   ht_eff;

    logic               kind_reg;
    logic [32:0]        item_reg;

    logic [TOT_W-1:0]   fed_reg;
    logic [TOT_W-1:0]   m_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ADDR_W-1:0]  wp_reg;
    logic [ADDR_W-1:0]  cptr_reg;
    logic [3:0]         tap_reg;

    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic                     cnd_reg;

    logic               store, ready, emit, last_px;
    logic [TOT_W:0]     fed_inc, need;
    logic [1:0]         tr, tc;
    logic signed [ADDR_W:0] roff, coff, asum;
    logic [3:0]         ctap;
    logic signed [GRAD_W-1:0] val;

    function automatic logic [1:0] tap_row(input logic [3:0] t);
        logic [1:0] r;
        unique case (t)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] tap_col(input logic [3:0] t);
        logic [1:0] c;
        unique case (t)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    // horn weights: x from right minus left, y from bottom minus top
    function automatic logic signed [GRAD_W-1:0] wx_term(input logic [3:0] t,
                                                         input logic signed [GRAD_W-1:0] v);
        logic signed [GRAD_W-1:0] r;
        unique case (t)
            4'd0, 4'd6: r = -v;
            4'd3:       r = -(v <<< 1);
            4'd2, 4'd8: r = v;
            4'd5:       r = v <<< 1;
            default:    r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [GRAD_W-1:0] wy_term(input logic [3:0] t,
                                                         input logic signed [GRAD_W-1:0] v);
        logic signed [GRAD_W-1:0] r;
        unique case (t)
            4'd0, 4'd2: r = -v;
            4'd1:       r = -(v <<< 1);
            4'd6, 4'd8: r = v;
            4'd7:       r = v <<< 1;
            default:    r = '0;
        endcase
        return r;
    endfunction

    // out-of-range geometry folds into the supported range
    always_comb
    begin
        if (cfg.image_width == '0)
            wd_eff = COL_W'(1);
        else if (32'(cfg.image_width) > MAX_WIDTH)
            wd_eff = COL_W'(MAX_WIDTH);
        else
            wd_eff = COL_W'(cfg.image_width);
        ht_eff = (cfg.image_height == '0) ? ROW_W'(1) : cfg.image_height;
    end

    assign store   = (kind_reg == KIND_SAMPLE) && (fed_reg < total_reg);
    assign fed_inc = {1'b0, fed_reg} + 1'b1;
    assign need    = {1'b0, m_reg} + (TOT_W+1)'(wd_reg) + (TOT_W+1)'(2);
    assign ready   = store ? (fed_inc >= need) : (fed_reg == total_reg);
    assign emit    = (m_reg < total_reg) && ready;
    assign last_px = ({1'b0, m_reg} + 1'b1) >= {1'b0, total_reg};

    // neighbour address around the centre, borders replicate
    always_comb
    begin
        tr = tap_row(tap_reg);
        tc = tap_col(tap_reg);
        if (tr == 2'd0 && row_reg != '0)
            roff = -$signed((ADDR_W+1)'(wd_reg));
        else if (tr == 2'd2 && ({1'b0, row_reg} + 1'b1) < {1'b0, ht_reg})
            roff = $signed((ADDR_W+1)'(wd_reg));
        else
            roff = '0;
        if (tc == 2'd0 && col_reg != '0)
            coff = -$signed((ADDR_W+1)'(1));
        else if (tc == 2'd2 && ({1'b0, col_reg} + 1'b1) < {1'b0, wd_reg})
            coff = $signed((ADDR_W+1)'(1));
        else
            coff = '0;
        asum = $signed({1'b0, cptr_reg}) + roff + coff;
        if (asum < 0)
            raddr = ADDR_W'(asum + $signed((ADDR_W+1)'(RING_SIZE)));
        else if (asum >= $signed((ADDR_W+1)'(RING_SIZE)))
            raddr = ADDR_W'(asum - $signed((ADDR_W+1)'(RING_SIZE)));
        else
            raddr = ADDR_W'(asum);
    end

    assign ctap = tap_reg - 1'b1;
    assign val  = rd_reg[32] ? '0 : GRAD_W'($signed(rd_reg[31:0]));

    always_ff @(posedge clk)
    begin
        if (state_reg == F_EVAL && store)
        begin
            line_mem[wp_reg] <= item_reg;
        end
        rd_reg <= line_mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (in_valid) state_next = F_EVAL;
            F_EVAL: state_next = emit ? F_READ : F_IDLE;
            F_READ: if (tap_reg == 4'(TAP_N)) state_next = F_PUSH;
            F_PUSH: if (!full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    assign in_ready            = (state_reg == F_IDLE);
    assign push                = (state_reg == F_PUSH) && !full;
    assign push_data.gx        = gx_reg;
    assign push_data.gy        = gy_reg;
    assign push_data.center_nd = cnd_reg;
    assign push_data.frame_end = last_px;

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            kind_reg <= in_kind;
            item_reg <= {in_nd, in_elev};
        end
        if (state_reg == F_EVAL)
        begin
            gx_reg  <= '0;
            gy_reg  <= '0;
            cnd_reg <= 1'b0;
        end
        else if (state_reg == F_READ && tap_reg != '0)
        begin
            gx_reg <= gx_reg + wx_term(ctap, val);
            gy_reg <= gy_reg + wy_term(ctap, val);
            if (ctap == 4'd4)
                cnd_reg <= rd_reg[32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            wd_reg    <= COL_W'(MAX_WIDTH);
            ht_reg    <= ROW_W'(4096);
            total_reg <= TOT_W'(MAX_WIDTH * 4096);
            fed_reg   <= '0;
            m_reg     <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            wp_reg    <= '0;
            cptr_reg  <= '0;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wd_reg    <= wd_eff;
            ht_reg    <= ht_eff;
            total_reg <= TOT_W'(wd_eff * ht_eff);
            if (frame_clear)
            begin
                fed_reg  <= '0;
                m_reg    <= '0;
                col_reg  <= '0;
                row_reg  <= '0;
                wp_reg   <= '0;
                cptr_reg <= '0;
            end
            else
            begin
                if (state_reg == F_EVAL)
                begin
                    tap_reg <= '0;
                    if (store)
                    begin
                        fed_reg <= fed_inc[TOT_W-1:0];
                        wp_reg  <= (wp_reg == ADDR_W'(RING_SIZE - 1)) ? '0 : wp_reg + 1'b1;
                    end
                end
                if (state_reg == F_READ)
                    tap_reg <= tap_reg + 1'b1;
                if (push)
                begin
                    if (last_px)
                    begin
                        fed_reg  <= '0;
                        m_reg    <= '0;
                        col_reg  <= '0;
                        row_reg  <= '0;
                        wp_reg   <= '0;
                        cptr_reg <= '0;
                    end
                    else
                    begin
                        m_reg    <= m_reg + 1'b1;
                        cptr_reg <= (cptr_reg == ADDR_W'(RING_SIZE - 1)) ? '0 : cptr_reg + 1'b1;
                        if (({1'b0, col_reg} + 1'b1) >= {1'b0, wd_reg})
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + 1'b1;
                        end
                        else
                            col_reg <= col_reg + 1'b1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/hhr_shade.sv
`default_nettype none
module hhr_shade (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hhr_pkg::cfg_t cfg,
    input  wire logic          empty,
    input  wire hhr_pkg::win_t win,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_shade,
    output logic               out_last
);
    import hhr_pkg::*;

    back_state_t   state_reg, state_next;
    logic [3:0]    step_reg;

    logic [34:0]   ax_reg, ay_reg;
    logic          np_reg, nq_reg, fe_reg;
    logic [58:0]   mp_reg, mq_reg;
    logic [24:0]   md_reg;
    logic signed [47:0] term_q_reg;
    logic          dneg_reg;
    logic [46:0]   dmag_reg;
    logic [54:0]   nbase_reg;
    logic [61:0]   s_reg;
    logic [62:0]   sacc_reg;
    logic signed [63:0] num_reg;
    logic [62:0]   v_reg, r_reg;
    logic [4:0]    it_reg;
    logic [71:0]   rem_reg;
    logic [61:0]   dv_reg;
    logic [7:0]    q_reg;
    logic [7:0]    shade_reg;
    logic          out_valid_reg;
    logic [7:0]    out_shade_reg;
    logic          out_last_reg;

    logic [31:0]   mul_a, mul_b;
    logic [63:0]   prod_reg;
    logic [15:0]   abs_sa, abs_ca;
    logic signed [GRAD_W-1:0] gx_abs, gy_abs;
    logic signed [47:0] pterm, diff;
    logic [62:0]   sacc_full, bitv, rplus;
    logic [30:0]   r31;
    logic signed [63:0] tval;
    logic [71:0]   n72, dsh;
    logic          sat, go_shift, sq_ge;

    assign abs_sa = cfg.sin_azimuth[15] ? 16'(-cfg.sin_azimuth) : cfg.sin_azimuth;
    assign abs_ca = cfg.cos_azimuth[15] ? 16'(-cfg.cos_azimuth) : cfg.cos_azimuth;
    assign gx_abs = win.gx[GRAD_W-1] ? -win.gx : win.gx;
    assign gy_abs = win.gy[GRAD_W-1] ? -win.gy : win.gy;

    // shared multiplier, operands picked by the sequencer step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == B_MULA)
        begin
            unique case (step_reg)
                4'd0:    begin mul_a = 32'(ax_reg[16:0]);  mul_b = 32'(cfg.scale_x); end
                4'd1:    begin mul_a = 32'(ax_reg[34:17]); mul_b = 32'(cfg.scale_x); end
                4'd2:    begin mul_a = 32'(ay_reg[16:0]);  mul_b = 32'(cfg.scale_y); end
                4'd3:    begin mul_a = 32'(ay_reg[34:17]); mul_b = 32'(cfg.scale_y); end
                default: ;
            endcase
        end
        else if (state_reg == B_MULB)
        begin
            unique case (step_reg)
                4'd0:    begin mul_a = 32'(mq_reg[29:0]);    mul_b = 32'(abs_sa); end
                4'd1:    begin mul_a = 32'(mp_reg[29:0]);    mul_b = 32'(abs_ca); end
                4'd2:    begin mul_a = 32'(cfg.cos_zenith);  mul_b = 32'(md_reg); end
                4'd3:    begin mul_a = 32'(md_reg);          mul_b = 32'(md_reg); end
                4'd4:    begin mul_a = 32'(mp_reg[29:0]);    mul_b = 32'(mp_reg[29:0]); end
                4'd5:    begin mul_a = 32'(mq_reg[29:0]);    mul_b = 32'(mq_reg[29:0]); end
                4'd6:    begin mul_a = dmag_reg[31:0];       mul_b = 32'(cfg.sin_zenith); end
                4'd7:    begin mul_a = 32'(dmag_reg[46:32]); mul_b = 32'(cfg.sin_zenith); end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign pterm     = $signed({2'b0, prod_reg[45:0]});
    assign diff      = term_q_reg - (((np_reg ^ cfg.cos_azimuth[15])) ? -pterm : pterm);
    assign sacc_full = sacc_reg + {prod_reg[30:0], 32'b0};
    // the unit slope never exceeds 30 bits, so only the gradients decide
    assign go_shift  = |(mp_reg[58:30] | mq_reg[58:30]);
    assign bitv      = 63'(1) << {it_reg, 1'b0};
    assign rplus     = r_reg + bitv;
    assign sq_ge     = v_reg >= rplus;
    assign r31       = r_reg[30:0];
    assign tval      = num_reg + $signed({3'b0, r31, 30'b0});
    assign n72       = {1'b0, tval[62:0], 8'b0} - {9'b0, tval[62:0]};
    assign sat       = n72 >= {2'b0, r31, 31'b0, 8'b0};
    assign dsh       = {10'b0, dv_reg} << it_reg[2:0];

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = win.center_nd ? B_DONE : B_MULA;
                end
            end
            B_MULA:  if (step_reg == 4'd4) state_next = B_SHIFT;
            B_SHIFT: if (!go_shift) state_next = B_MULB;
            B_MULB:  if (step_reg == 4'd8) state_next = B_SQRT;
            B_SQRT:  if (it_reg == '0) state_next = B_PREP;
            B_PREP:
            begin
                if (r31 == '0 || tval <= 0 || sat)
                    state_next = B_DONE;
                else
                    state_next = B_DIV;
            end
            B_DIV:   if (it_reg == '0) state_next = B_DONE;
            B_DONE:  if (!out_valid_reg || out_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                ax_reg    <= gx_abs[34:0];
                ay_reg    <= gy_abs[34:0];
                np_reg    <= win.gx[GRAD_W-1];
                nq_reg    <= win.gy[GRAD_W-1];
                fe_reg    <= win.frame_end;
                md_reg    <= 25'(1 << 24);
                shade_reg <= '0;
            end
            B_MULA:
            begin
                unique case (step_reg)
                    4'd1:    mp_reg <= 59'(prod_reg[41:0]);
                    4'd2:    mp_reg <= mp_reg + {prod_reg[41:0], 17'b0};
                    4'd3:    mq_reg <= 59'(prod_reg[41:0]);
                    4'd4:    mq_reg <= mq_reg + {prod_reg[41:0], 17'b0};
                    default: ;
                endcase
            end
            B_SHIFT:
            begin
                if (go_shift)
                begin
                    mp_reg <= mp_reg >> 1;
                    mq_reg <= mq_reg >> 1;
                    md_reg <= md_reg >> 1;
                end
            end
            B_MULB:
            begin
                unique case (step_reg)
                    4'd1: term_q_reg <= (nq_reg ^ cfg.sin_azimuth[15]) ? -pterm : pterm;
                    4'd2:
                    begin
                        dneg_reg <= diff[47];
                        dmag_reg <= diff[47] ? 47'(-diff) : diff[46:0];
                    end
                    4'd3: nbase_reg <= {prod_reg[39:0], 15'b0};
                    4'd4: s_reg <= prod_reg[61:0];
                    4'd5: s_reg <= s_reg + prod_reg[61:0];
                    4'd6: s_reg <= s_reg + prod_reg[61:0];
                    4'd7: sacc_reg <= 63'(prod_reg[46:0]);
                    4'd8:
                    begin
                        num_reg <= $signed({9'b0, nbase_reg}) +
                                   (dneg_reg ? -$signed({1'b0, sacc_full})
                                             :  $signed({1'b0, sacc_full}));
                        v_reg   <= 63'(s_reg);
                        r_reg   <= '0;
                        it_reg  <= 5'd31;
                    end
                    default: ;
                endcase
            end
            B_SQRT:
            begin
                if (sq_ge)
                begin
                    v_reg <= v_reg - rplus;
                    r_reg <= (r_reg >> 1) + bitv;
                end
                else
                    r_reg <= r_reg >> 1;
                it_reg <= it_reg - 1'b1;
            end
            B_PREP:
            begin
                if (r31 == '0 || tval <= 0)
                    shade_reg <= '0;
                else if (sat)
                    shade_reg <= 8'd255;
                rem_reg <= n72;
                dv_reg  <= {r31, 31'b0};
                q_reg   <= '0;
                it_reg  <= 5'd7;
            end
            B_DIV:
            begin
                if (rem_reg >= dsh)
                begin
                    rem_reg <= rem_reg - dsh;
                    q_reg   <= q_reg | (8'd1 << it_reg[2:0]);
                    if (it_reg == '0) shade_reg <= q_reg | 8'd1;
                end
                else if (it_reg == '0)
                    shade_reg <= q_reg;
                it_reg <= it_reg - 1'b1;
            end
            default: ;
        endcase
        if (state_reg == B_DONE && (!out_valid_reg || out_ready))
        begin
            out_shade_reg <= shade_reg;
            out_last_reg  <= fe_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_MULA || state_reg == B_MULB)
                step_reg <= (state_next == state_reg) ? step_reg + 1'b1 : '0;
            else
                step_reg <= '0;
            if (state_reg == B_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_shade = out_shade_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

>>> hdl/horn_hillshade_raster.sv
`default_nettype none
// Horn hillshade over a raster elevation stream. Samples enter in raster order on the
// slave stream (tuser = kind: 0 sample, 1 flush); each result is the grey shade of the
// pixel one row and one pixel behind the newest sample, with tlast on the last pixel of
// the frame, and flush requests drain the final row once every sample is in. A front
// stage keeps a ring line buffer of 2*MAX_WIDTH+3 entries and takes no new request
// while it is busy with the last one; a request that completes a window costs nine
// reads of its single read port and a queue push that waits while the queue is full.
// Window gradients go through a two-entry queue to the shading back end, which runs a
// shared 32x32 multiplier sequence, a normalizing shift of up to 29 steps, a 32-step
// square root and an 8-step divide, and this back end sets the sustained rate. A
// no-data centre shades to 0 without the arithmetic. Writing image_width or
// image_height restarts the frame; the other registers apply at once.
module horn_hillshade_raster (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // elevation [31:0], no_data [32], zero pad
    input  wire logic [0:0]  s_axis_tuser,   // kind [0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // shade [7:0]
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata
);
    import hhr_pkg::*;

    cfg_t  cfg_reg;
    logic  clear;
    logic  q_push, q_full, q_pop, q_empty;
    win_t  q_in, q_out;

    // geometry writes abandon the frame in progress
    assign clear = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= 13'd4096;
            cfg_reg.image_height <= 16'd4096;
            cfg_reg.cos_zenith   <= 15'd23170;
            cfg_reg.sin_zenith   <= 15'd23170;
            cfg_reg.cos_azimuth  <= 16'sd23170;
            cfg_reg.sin_azimuth  <= 16'sd23170;
            cfg_reg.scale_x      <= 24'd65536;
            cfg_reg.scale_y      <= 24'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:   cfg_reg.image_width  <= cfg_wdata[12:0];
                CFG_HEIGHT:  cfg_reg.image_height <= cfg_wdata[15:0];
                CFG_COS_ZEN: cfg_reg.cos_zenith   <= cfg_wdata[14:0];
                CFG_SIN_ZEN: cfg_reg.sin_zenith   <= cfg_wdata[14:0];
                CFG_COS_AZ:  cfg_reg.cos_azimuth  <= $signed(cfg_wdata[15:0]);
                CFG_SIN_AZ:  cfg_reg.sin_azimuth  <= $signed(cfg_wdata[15:0]);
                CFG_SCALE_X: cfg_reg.scale_x      <= cfg_wdata;
                CFG_SCALE_Y: cfg_reg.scale_y      <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // window gathering and frame bookkeeping
    hhr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .frame_clear (clear),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_kind     (s_axis_tuser[0]),
        .in_elev     (s_axis_tdata[31:0]),
        .in_nd       (s_axis_tdata[32]),
        .push        (q_push),
        .push_data   (q_in),
        .full        (q_full)
    );

    // decouples gathering from shading
    hhr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // fixed point shading with registered output
    hhr_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .empty     (q_empty),
        .win       (q_out),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_shade (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

>>> bench/hhr_shade_checker.sv
`timescale 1ns / 1ps
module hhr_shade_checker
    import hhr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic [0:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,
    input  wire logic        m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata,
    output int               fail_count,
    output int               pending
);

    typedef struct {
        logic [7:0] shade;
        logic       last;
    } shade_result_t;

    shade_result_t shade_queue[$];

    logic        [12:0] width_reg;
    logic        [15:0] height_reg;
    logic        [14:0] cos_zen, sin_zen;
    logic signed [15:0] cos_az, sin_az;
    logic        [23:0] scale_x, scale_y;

    logic [32:0] line_store [RING_SIZE];
    logic [32:0] win [9];
    longint unsigned row_idx, col_idx, fed_total;

    assign pending = shade_queue.size();

    function automatic longint unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic longint unsigned eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint tap(input int n);
        if (win[n][32]) return 0;
        return longint'($signed(win[n][31:0]));
    endfunction

    function automatic logic [7:0] horn_shade();
        longint gx, gy, pp, qq, dd, num, t;
        longint unsigned mp, mq, md, mx, s, r, u, w;
        int bl, k;
        bit np, nq;
        gx = (tap(2) + 2 * tap(5) + tap(8)) - (tap(0) + 2 * tap(3) + tap(6));
        gy = (tap(6) + 2 * tap(7) + tap(8)) - (tap(0) + 2 * tap(1) + tap(2));
        np = gx < 0;
        nq = gy < 0;
        mp = longint'(np ? -gx : gx) * longint'(scale_x);
        mq = longint'(nq ? -gy : gy) * longint'(scale_y);
        md = 64'd1 << 24;
        mx = md;
        if (mp > mx) mx = mp;
        if (mq > mx) mx = mq;
        bl = 0;
        while (mx != 0)
        begin
            bl++;
            mx >>= 1;
        end
        k = (bl > 30) ? bl - 30 : 0;
        mp >>= k;
        mq >>= k;
        md >>= k;
        pp = np ? -longint'(mp) : longint'(mp);
        qq = nq ? -longint'(mq) : longint'(mq);
        dd = longint'(md);
        num = longint'(cos_zen) * dd * 32768
            + longint'(sin_zen) * (qq * longint'(sin_az) - pp * longint'(cos_az));
        s = md * md + mp * mp + mq * mq;
        r = root64(s);
        if (r == 0) return 8'd0;
        t = num + longint'(r << 30);
        if (t <= 0) return 8'd0;
        u = t;
        w = 255 * (u / r) + (255 * (u % r)) / r;
        w >>= 31;
        return (w > 255) ? 8'd255 : w[7:0];
    endfunction

    // one accepted request: store a sample while the frame needs one, then emit a centre if one is due
    task automatic take_request(input bit is_flush, input logic [32:0] sample);
        longint unsigned wd = eff_width();
        longint unsigned ht = eff_height();
        longint unsigned total = wd * ht;
        longint unsigned m = row_idx * wd + col_idx;
        longint unsigned rr, cc;
        bit stored = 0;
        bit ready;
        shade_result_t res;
        if (!is_flush && fed_total < total)
        begin
            line_store[fed_total % RING_SIZE] = sample;
            fed_total++;
            stored = 1;
        end
        ready = stored ? (fed_total >= m + wd + 2) : (fed_total == total);
        if (m >= total || !ready) return;
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                rr = row_idx;
                cc = col_idx;
                if (dr == 0 && rr > 0) rr--;
                if (dr == 2 && rr + 1 < ht) rr++;
                if (dc == 0 && cc > 0) cc--;
                if (dc == 2 && cc + 1 < wd) cc++;
                win[dr * 3 + dc] = line_store[(rr * wd + cc) % RING_SIZE];
            end
        end
        res.shade = win[4][32] ? 8'd0 : horn_shade();
        res.last = 1'b0;
        col_idx++;
        if (col_idx >= wd)
        begin
            col_idx = 0;
            row_idx++;
        end
        if (m + 1 >= total)
        begin
            res.last = 1'b1;
            row_idx = 0;
            col_idx = 0;
            fed_total = 0;
        end
        shade_queue.insert(shade_queue.size(), res);
    endtask

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = 13'd4096;
            height_reg = 16'd4096;
            cos_zen    = 15'd23170;
            sin_zen    = 15'd23170;
            cos_az     = 16'sd23170;
            sin_az     = 16'sd23170;
            scale_x    = 24'd65536;
            scale_y    = 24'd65536;
            foreach (win[n]) win[n] = '0;
            row_idx    = 0;
            col_idx    = 0;
            fed_total  = 0;
            shade_queue.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WIDTH:
                    begin
                        width_reg = cfg_wdata[12:0];
                        row_idx = 0; col_idx = 0; fed_total = 0;
                    end
                    CFG_HEIGHT:
                    begin
                        height_reg = cfg_wdata[15:0];
                        row_idx = 0; col_idx = 0; fed_total = 0;
                    end
                    CFG_COS_ZEN: cos_zen = cfg_wdata[14:0];
                    CFG_SIN_ZEN: sin_zen = cfg_wdata[14:0];
                    CFG_COS_AZ:  cos_az = cfg_wdata[15:0];
                    CFG_SIN_AZ:  sin_az = cfg_wdata[15:0];
                    CFG_SCALE_X: scale_x = cfg_wdata;
                    CFG_SCALE_Y: scale_y = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                take_request(s_axis_tuser[0] != KIND_SAMPLE, s_axis_tdata[32:0]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (shade_queue.size() == 0)
                    report($sformatf("unexpected result shade %0d", m_axis_tdata));
                else
                begin
                    if (m_axis_tdata !== shade_queue[0].shade)
                        report($sformatf("shade %0d, predicted %0d",
                                         m_axis_tdata, shade_queue[0].shade));
                    if (m_axis_tlast !== shade_queue[0].last)
                        report($sformatf("frame end %b, predicted %b",
                                         m_axis_tlast, shade_queue[0].last));
                    void'(shade_queue.pop_front());
                end
            end
        end
    end

endmodule

>>> bench/tb_horn_hillshade_raster.sv
`timescale 1ns / 1ps
module tb_horn_hillshade_raster;
    import hhr_pkg::*;

    localparam logic KIND_FLUSH    = ~KIND_SAMPLE;
    localparam int   STALL_LIMIT   = 20000;   // cycles with no handshake at all
    localparam int   SETTLE_CYCLES = 300;     // back end worst case plus margin
    localparam int   RANDOM_ITEMS  = 1600;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;    // elevation [31:0], no_data [32], zero pad
    logic [0:0]  s_axis_tuser;    // kind [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // shade [7:0]
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_wdata;

    int fail_count;
    int pending;
    int sent_requests;
    int stall_cycles = 0;
    bit calm;          // no idling on either side while set
    int elev_mode;     // how samples of the current frame are drawn
    int nd_percent;    // no-data density of the current frame
    logic [31:0] elev_base;

    horn_hillshade_raster u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    hhr_shade_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // result side backpressure, ready dropped with a 6 percent chance unless calm
    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 6);

    // watchdog: a long run of cycles with no handshake means the block hung
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one register write, a single cycle of write enable
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one request; tvalid stays high afterwards unless the next call idles
    task automatic push_request(input logic kind, input logic [31:0] elev, input logic nd);
        while (!calm && $urandom_range(99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, nd, elev};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sent_requests++;
    endtask

    // drain everything expected, then let the front stage settle before config
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] next_elevation();
        case (elev_mode)
            0: return elev_base + ((($urandom_range(0, 4095)) - 2048) << $urandom_range(0, 12));
            1: return $urandom;
            default:
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
        endcase
    endfunction

    // one frame of w x h pixels (effective sizes); a cut frame stops early
    task automatic run_frame(input int w, input int h, input bit cut);
        int count;
        count = cut ? $urandom_range(1, w * h) : w * h;
        for (int n = 0; n < count; n++)
        begin
            // stray flush in mid frame, gives nothing until all samples are in
            if ($urandom_range(99) < 5)
                push_request(KIND_FLUSH, $urandom, 1'($urandom_range(1)));
            push_request(KIND_SAMPLE, next_elevation(), $urandom_range(99) < nd_percent);
        end
        if (!cut)
        begin
            for (int n = 0; n < w + 1 + $urandom_range(0, 2); n++)
            begin
                // a sample after the frame is complete acts as a flush
                if ($urandom_range(99) < 10)
                    push_request(KIND_SAMPLE, $urandom, 1'($urandom_range(1)));
                else
                    push_request(KIND_FLUSH, $urandom, 1'($urandom_range(1)));
            end
        end
        quiesce();
    endtask

    function automatic logic [23:0] pick_scale();
        case ($urandom_range(4))
            0: return 24'd0;
            1: return 24'hFF_FFFF;
            2: return 24'd65536;
            3: return 24'($urandom_range(0, 1 << 18));
            default: return 24'($urandom);
        endcase
    endfunction

    initial
    begin
        int w_raw, h_raw, w_eff, h_eff, start_count, phase;
        logic [31:0] corner_vals [4];
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_SAMPLE;
        cfg_we        = 1'b0;
        cfg_index     = CFG_WIDTH;
        cfg_wdata     = '0;
        calm          = 1'b0;
        sent_requests = 0;
        elev_mode     = 1;
        nd_percent    = 10;
        elev_base     = '0;
        corner_vals   = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 3x3 frame of extreme elevations, full light, steep scale;
        // width written with junk in the upper bits to show masking
        write_reg(CFG_WIDTH, {11'h7FF, 13'd3});
        write_reg(CFG_HEIGHT, 24'd3);
        write_reg(CFG_COS_ZEN, 24'd32767);
        write_reg(CFG_SIN_ZEN, 24'd0);
        write_reg(CFG_COS_AZ, 24'h00_8000);
        write_reg(CFG_SIN_AZ, 24'h00_7FFF);
        write_reg(CFG_SCALE_X, 24'hFF_FFFF);
        write_reg(CFG_SCALE_Y, 24'd0);
        for (int n = 0; n < 9; n++)
        begin
            if (n == 2)
                push_request(KIND_FLUSH, '0, 1'b0);
            // no-data on the centre and on one corner neighbour
            push_request(KIND_SAMPLE, corner_vals[n % 4], n == 4 || n == 0);
        end
        push_request(KIND_SAMPLE, 32'h1234_5678, 1'b0);  // discarded, drains
        for (int n = 0; n < 4; n++)
            push_request(KIND_FLUSH, '0, 1'b0);
        quiesce();

        // single pixel frame, and grazing light from the opposite side
        write_reg(CFG_WIDTH, 24'd1);
        write_reg(CFG_HEIGHT, 24'd1);
        write_reg(CFG_SIN_ZEN, 24'd32767);
        write_reg(CFG_COS_ZEN, 24'd0);
        push_request(KIND_SAMPLE, 32'h8000_0000, 1'b0);
        push_request(KIND_FLUSH, '0, 1'b0);
        push_request(KIND_FLUSH, '0, 1'b0);
        quiesce();

        // tallest height with a narrow row: partial frame, abandoned by rewrite
        write_reg(CFG_WIDTH, 24'd2);
        write_reg(CFG_HEIGHT, 24'hFFFF);
        write_reg(CFG_SCALE_X, 24'd65536);
        write_reg(CFG_SCALE_Y, 24'hFF_FFFF);
        for (int n = 0; n < 12; n++)
            push_request(KIND_SAMPLE, $urandom, n == 7);
        quiesce();

        // widest row: oversized width acts as the maximum, zero height as one;
        // a partial row only, abandoned by the next rewrite
        write_reg(CFG_WIDTH, 24'h1FFF);
        write_reg(CFG_HEIGHT, 24'd0);
        write_reg(CFG_SCALE_X, 24'd4096);
        write_reg(CFG_SCALE_Y, 24'd4096);
        elev_mode = 0;
        elev_base = $urandom;
        calm = 1'b1;
        for (int n = 0; n < 64; n++)
            push_request(KIND_SAMPLE, next_elevation(), 1'b0);
        quiesce();
        calm = 1'b0;

        // random phases, mostly small frames
        start_count = sent_requests;
        phase = 0;
        while (sent_requests - start_count < RANDOM_ITEMS)
        begin
            calm = (phase >= 6 && phase < 12);
            case ($urandom_range(9))
                0:       w_raw = 0;
                1:       w_raw = $urandom_range(9, 40);
                default: w_raw = $urandom_range(1, 8);
            endcase
            h_raw = $urandom_range(0, 6);
            w_eff = (w_raw == 0) ? 1 : w_raw;
            h_eff = (h_raw == 0) ? 1 : h_raw;
            write_reg(CFG_WIDTH, 24'(w_raw));
            write_reg(CFG_HEIGHT, 24'(h_raw));
            if ($urandom_range(1))
            begin
                write_reg(CFG_COS_ZEN, 24'($urandom));
                write_reg(CFG_SIN_ZEN, 24'($urandom));
                write_reg(CFG_COS_AZ, 24'($urandom));
                write_reg(CFG_SIN_AZ, 24'($urandom));
            end
            write_reg(CFG_SCALE_X, pick_scale());
            write_reg(CFG_SCALE_Y, pick_scale());
            elev_mode  = $urandom_range(2);
            elev_base  = $urandom;
            nd_percent = ($urandom_range(3) == 0) ? 40 : 8;
            run_frame(w_eff, h_eff, $urandom_range(9) == 0);
            phase++;
        end
        calm = 1'b0;

        quiesce();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
hdl/hhr_pkg.sv
hdl/hhr_fifo.sv
hdl/hhr_front.sv
hdl/hhr_shade.sv
hdl/horn_hillshade_raster.sv
bench/hhr_shade_checker.sv
bench/tb_horn_hillshade_raster.sv
